// File: sv/sorted_priority_queue_unit_assert.svh
// Assertion macros for the checker file of the sorted priority queue.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// plain clocked property with active-low reset masking
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `SPQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `SPQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: sv/spq_pkg.sv
// Package for the sorted priority queue: sizes, command and status codes,
// cell control struct. Depends on nothing.
package spq_pkg;

    localparam int SPQ_CAPACITY  = 16;
    localparam int SPQ_KEY_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int SPQ_CMD_W    = 2;
    localparam int SPQ_KEYIO_W  = 32;
    localparam int SPQ_STATUS_W = 2;
    localparam int SPQ_OCC_W    = 5;
    localparam int SPQ_OUT_DATA_W = ((SPQ_KEYIO_W + SPQ_OCC_W + 7) / 8) * 8;

    typedef enum logic [SPQ_CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_PEEK    = 2'd2
    } t_spq_cmd;

    typedef enum logic [SPQ_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_spq_status;

    // broadcast to every cell for one word
    typedef struct packed {
        logic ins;  // insert the new key (queue not full)
        logic ext;  // drop the front key (queue not empty)
    } t_spq_ctl;

endpackage

// File: sv/spq_cell.sv
// One slot of the sorted chain: holds a key, keeps it, takes the new key or
// takes a neighbour's key. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int KEY_W    = SPQ_KEY_WIDTH,
    parameter int COUNT_W  = 5
) (
    input  logic               i_clk,
    input  t_spq_ctl           i_ctl,
    input  logic [KEY_W-1:0]   i_new_key,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_left_keep,  // left cell holds a key <= new key
    input  logic [KEY_W-1:0]   i_left_key,
    input  logic [KEY_W-1:0]   i_right_key,
    output logic               o_keep,
    output logic [KEY_W-1:0]   o_key
);

    localparam logic [COUNT_W-1:0] IdxC = COUNT_W'(IDX);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             occ;

    assign occ    = IdxC < i_count;
    assign o_keep = occ && (r_key <= i_new_key);
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        priority if (i_ctl.ins) begin
            priority if (o_keep) begin
                n_key = r_key;
            end else if (i_left_keep || (IDX == 0)) begin
                n_key = i_new_key;
            end else begin
                n_key = i_left_key;   // shift right to open the gap
            end
        end else if (i_ctl.ext) begin
            n_key = i_right_key;      // shift left over the removed front
        end else begin
            n_key = r_key;            // idle or read-only word
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// File: sv/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a chain of spq_cell slots, the
// key count and the output register. Depends on spq_pkg and spq_cell.
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata key_in, tuser command
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata key_out+occupancy,
//                                                  tuser status
//
// One word per cycle unless the output stalls: every cell compares the new key
// against its own slot in parallel and moves at most one step, so insert, extract
// and peek all finish in the cycle of acceptance; the result appears the cycle after.
// The input is taken whenever the output register is empty or being drained.
// Reset clears the key count and the output valid; slot keys are not reset and
// are only ever read below the count.
// A stalled output holds its word and stops further input until it is taken.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY  = SPQ_CAPACITY,
    parameter int KEY_WIDTH = SPQ_KEY_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [SPQ_KEYIO_W-1:0]    i_s_axis_tdata,   // [31:0] key_in
    input  logic [SPQ_CMD_W-1:0]      i_s_axis_tuser,   // [1:0] command
    // master side
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [SPQ_OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] key_out,
                                                        // [36:32] occupancy, rest 0
    output logic [SPQ_STATUS_W-1:0]   o_m_axis_tuser    // [1:0] status
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] FullCount = COUNT_W'(CAPACITY);
    localparam logic [COUNT_W-1:0] OneCount  = COUNT_W'(1);
    localparam int PAD_W = SPQ_OUT_DATA_W - SPQ_KEYIO_W - SPQ_OCC_W;

    // ---- handshake ----
    logic accept;
    assign o_s_axis_tready = !o_m_axis_tvalid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // ---- input key fitted to the slot width ----
    logic [KEY_WIDTH+SPQ_KEYIO_W-1:0] key_in_ext;
    logic [KEY_WIDTH-1:0]             new_key;
    assign key_in_ext = {{KEY_WIDTH{1'b0}}, i_s_axis_tdata};
    assign new_key    = key_in_ext[KEY_WIDTH-1:0];

    // ---- count and decode ----
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               empty;
    logic               full;
    t_spq_cmd           cmd;
    t_spq_ctl           ctl;

    assign empty = (r_count == '0);
    assign full  = (r_count == FullCount);
    assign cmd   = t_spq_cmd'(i_s_axis_tuser);

    // ---- cell chain ----
    logic [KEY_WIDTH-1:0] keys [CAPACITY];
    logic                 keep [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_keep;
        logic [KEY_WIDTH-1:0] right_key;

        if (g == 0) begin : g_first
            assign left_key  = new_key;
            assign left_keep = 1'b0;
        end else begin : g_inner
            assign left_key  = keys[g-1];
            assign left_keep = keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key = keys[g];
        end else begin : g_mid
            assign right_key = keys[g+1];
        end

        spq_cell #(
            .IDX     (g),
            .KEY_W   (KEY_WIDTH),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new_key   (new_key),
            .i_count     (r_count),
            .i_left_keep (left_keep),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_keep      (keep[g]),
            .o_key       (keys[g])
        );
    end

    // ---- result of this word ----
    logic [KEY_WIDTH-1:0] res_key;
    t_spq_status          res_status;

    always_comb begin
        ctl        = '0;
        n_count    = r_count;
        res_key    = '0;
        res_status = ST_OK;
        unique case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    res_status = ST_FULL;
                    res_key    = keys[0];
                end else begin
                    ctl.ins = accept;
                    n_count = r_count + OneCount;
                    // equal keys go behind, so the front only moves on a smaller key
                    res_key = (empty || (new_key < keys[0])) ? new_key : keys[0];
                end
            end
            CMD_EXTRACT: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    ctl.ext = accept;
                    n_count = r_count - OneCount;
                    res_key = keys[0];
                end
            end
            default: begin   // peek, and the unused code behaves as peek
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_key = keys[0];
                end
            end
        endcase
    end

    // fit key and count to the fixed output fields
    logic [KEY_WIDTH+SPQ_KEYIO_W-1:0] res_key_ext;
    logic [COUNT_W+SPQ_OCC_W-1:0]     occ_ext;
    assign res_key_ext = {{SPQ_KEYIO_W{1'b0}}, res_key};
    assign occ_ext     = {{SPQ_OCC_W{1'b0}}, n_count};

    // ---- registers ----
    logic                      r_m_valid;
    logic [SPQ_OUT_DATA_W-1:0] r_m_data;
    logic [SPQ_STATUS_W-1:0]   r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_m_data <= {{PAD_W{1'b0}}, occ_ext[SPQ_OCC_W-1:0],
                         res_key_ext[SPQ_KEYIO_W-1:0]};
            r_m_user <= res_status;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

// File: sv/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit_assert.svh.
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [SPQ_OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [SPQ_STATUS_W-1:0]   o_m_axis_tuser
);

    localparam logic [SPQ_OCC_W-1:0] FullOcc = SPQ_OCC_W'(CAPACITY);

    logic [SPQ_OCC_W-1:0]   occ;
    logic [SPQ_KEYIO_W-1:0] key;
    assign occ = o_m_axis_tdata[SPQ_KEYIO_W+SPQ_OCC_W-1:SPQ_KEYIO_W];
    assign key = o_m_axis_tdata[SPQ_KEYIO_W-1:0];

    // an empty report carries a zero key and an empty queue
    `SPQ_ASSERT_IMP(a_empty_word, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY),
        (key == '0) && (occ == '0), "empty status with key or occupancy set")

    // a dropped insert only happens on a full queue
    `SPQ_ASSERT_IMP(a_full_word, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL),
        occ == FullOcc, "full status below capacity")

    // status code never the unused one, occupancy never beyond capacity
    `SPQ_ASSERT_IMP(a_status_occ, i_clk, i_rst_n, o_m_axis_tvalid,
        ((o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_EMPTY) ||
         (o_m_axis_tuser == ST_FULL)) && ((CAPACITY >= 32) || (occ <= FullOcc)),
        "bad status or occupancy")

    // stalled result holds
    `SPQ_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "output word changed while stalled")

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
